>>> rtl/core/bpl_pkg.sv
`default_nettype none
package bpl_pkg;

    localparam int unsigned NUM_BUTTONS = 3;
    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned EVT_WIDTH = 2;

    localparam logic [EVT_WIDTH-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVT_WIDTH-1:0] EVT_SHORT = 2'd1;
    localparam logic [EVT_WIDTH-1:0] EVT_LONG  = 2'd2;

    localparam logic [1:0] REG_LONG_PRESS_TICKS = 2'd0;
    localparam logic [1:0] REG_UPDATE_PERIOD    = 2'd1;
    localparam logic [1:0] REG_BLINK_PERIOD     = 2'd2;
    localparam logic [1:0] REG_BLINK_ON_TICKS   = 2'd3;

    localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS_TICKS = 16'd20;
    localparam logic [CFG_WIDTH-1:0] RST_UPDATE_PERIOD    = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_BLINK_PERIOD     = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_BLINK_ON_TICKS   = 16'd5;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] buttons_raw;
    } t_in_word;

    typedef struct packed {
        logic [EVT_WIDTH-1:0] button1_event;
        logic [EVT_WIDTH-1:0] button2_event;
        logic [EVT_WIDTH-1:0] button3_event;
        logic                 update_pulse;
        logic                 blink_on;
    } t_out_word;

    typedef struct packed {
        logic [1:0]           index;
        logic [CFG_WIDTH-1:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] update_period;
        logic [CFG_WIDTH-1:0] blink_period;
        logic [CFG_WIDTH-1:0] blink_on_ticks;
    } t_timer_cfg;

    typedef struct packed {
        logic accept;
        logic pressed;
    } t_lane_ctrl;

endpackage
`default_nettype wire

>>> rtl/core/bpl_stream_if.sv
`default_nettype none
interface bpl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bpl_lane.sv
`default_nettype none
module bpl_lane
    import bpl_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_lane_ctrl           i_ctrl,
    input  wire logic [CFG_WIDTH-1:0] i_long_press_ticks,
    output logic [EVT_WIDTH-1:0]      o_event
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic [COUNT_WIDTH-1:0] r_hold, n_hold;
    logic                   r_prev, n_prev;
    logic [CMP_W-1:0]       w_hold_ext, w_long_ext;

    assign w_hold_ext = CMP_W'(r_hold);
    assign w_long_ext = CMP_W'(i_long_press_ticks);

    always_comb begin
        o_event = EVT_NONE;
        if (!i_ctrl.pressed && r_prev) begin
            o_event = (w_hold_ext < w_long_ext) ? EVT_SHORT : EVT_LONG;
        end
    end

    always_comb begin
        n_hold = r_hold;
        n_prev = r_prev;
        if (i_ctrl.accept) begin
            n_prev = i_ctrl.pressed;
            if (i_ctrl.pressed) begin
                if (r_hold != {COUNT_WIDTH{1'b1}}) begin
                    n_hold = r_hold + COUNT_WIDTH'(1);
                end
            end else if (r_prev) begin
                n_hold = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_prev <= 1'b0;
        end else begin
            r_hold <= n_hold;
            r_prev <= n_prev;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bpl_timer.sv
`default_nettype none
module bpl_timer
    import bpl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_timer_cfg i_cfg,
    output logic            o_update_pulse,
    output logic            o_blink_on
);

    logic [CFG_WIDTH-1:0] r_update, n_update;
    logic [CFG_WIDTH-1:0] r_blink, n_blink;
    logic [CFG_WIDTH:0]   w_update_inc, w_blink_inc;

    assign w_update_inc   = {1'b0, r_update} + (CFG_WIDTH+1)'(1);
    assign w_blink_inc    = {1'b0, r_blink} + (CFG_WIDTH+1)'(1);
    assign o_update_pulse = (w_update_inc >= {1'b0, i_cfg.update_period});
    assign o_blink_on     = (r_blink < i_cfg.blink_on_ticks);

    always_comb begin
        n_update = r_update;
        n_blink  = r_blink;
        if (i_accept) begin
            n_update = o_update_pulse ? '0 : w_update_inc[CFG_WIDTH-1:0];
            n_blink  = (w_blink_inc >= {1'b0, i_cfg.blink_period}) ?
                       '0 : w_blink_inc[CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update <= '0;
            r_blink  <= '0;
        end else begin
            r_update <= n_update;
            r_blink  <= n_blink;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/button_press_length_classifier_core.sv
`default_nettype none
// channel  | dir | word       | fields
// i_in     | in  | t_in_word  | buttons_raw (active-low levels, one tick per word)
// o_out    | out | t_out_word | button1..3_event, update_pulse, blink_on
// i_cfg    | in  | t_cfg_word | index (0..3), value (16 bit)
//
// one tick word per clock unless o_out stalls; the output register holds its result word
// three hold-count lanes and one period timer work in the same cycle, merged into that register
// reset is synchronous, active low; all registers but the output word return to their reset values
// o_out stalls hold the output register; i_in is taken whenever that register is free or drains
// i_cfg is always ready; a valid word writes the config register that its index names
module button_press_length_classifier_core
    import bpl_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bpl_stream_if.sink   i_in,
    bpl_stream_if.source o_out,
    bpl_stream_if.sink   i_cfg
);

    logic [CFG_WIDTH-1:0] r_long_press_ticks;
    t_timer_cfg           r_timer_cfg;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_word;
    logic                 w_accept;
    logic [NUM_BUTTONS-1:0] w_pressed;
    logic [EVT_WIDTH-1:0] w_event [NUM_BUTTONS];
    logic                 w_update_pulse, w_blink_on;
    t_cfg_word            w_cfg;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_pressed   = ~i_in.data.buttons_raw;
    assign i_cfg.ready = 1'b1;
    assign w_cfg       = i_cfg.data;

    // per-button lanes
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        t_lane_ctrl w_ctrl;
        assign w_ctrl.accept  = w_accept;
        assign w_ctrl.pressed = w_pressed[g];
        bpl_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .i_clk              (i_clk),
            .i_rst_n            (i_rst_n),
            .i_ctrl             (w_ctrl),
            .i_long_press_ticks (r_long_press_ticks),
            .o_event            (w_event[g])
        );
    end

    bpl_timer u_timer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cfg          (r_timer_cfg),
        .o_update_pulse (w_update_pulse),
        .o_blink_on     (w_blink_on)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks         <= RST_LONG_PRESS_TICKS;
            r_timer_cfg.update_period  <= RST_UPDATE_PERIOD;
            r_timer_cfg.blink_period   <= RST_BLINK_PERIOD;
            r_timer_cfg.blink_on_ticks <= RST_BLINK_ON_TICKS;
        end else if (i_cfg.valid) begin
            unique case (w_cfg.index)
                REG_LONG_PRESS_TICKS: r_long_press_ticks         <= w_cfg.value;
                REG_UPDATE_PERIOD:    r_timer_cfg.update_period  <= w_cfg.value;
                REG_BLINK_PERIOD:     r_timer_cfg.blink_period   <= w_cfg.value;
                REG_BLINK_ON_TICKS:   r_timer_cfg.blink_on_ticks <= w_cfg.value;
                default: ;
            endcase
        end
    end

    // merge stage
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word.button1_event <= w_event[0];
            r_out_word.button2_event <= w_event[1];
            r_out_word.button3_event <= w_event[2];
            r_out_word.update_pulse  <= w_update_pulse;
            r_out_word.blink_on      <= w_blink_on;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

endmodule
`default_nettype wire

>>> dv/button_press_length_classifier_core_test.sv
`timescale 1ns / 1ps
module button_press_length_classifier_core_test;
    import bpl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpl_stream_if #(.t_payload(t_in_word))  in_if ();
    bpl_stream_if #(.t_payload(t_out_word)) out_if ();
    bpl_stream_if #(.t_payload(t_cfg_word)) cfg_if ();

    button_press_length_classifier_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] lp_ticks   = RST_LONG_PRESS_TICKS;
    logic [15:0] upd_period = RST_UPDATE_PERIOD;
    logic [15:0] blk_period = RST_BLINK_PERIOD;
    logic [15:0] blk_on     = RST_BLINK_ON_TICKS;
    logic [15:0] hold_cnt [NUM_BUTTONS] = '{16'd0, 16'd0, 16'd0};
    logic [2:0]  was_pressed = 3'b000;
    logic [15:0] upd_cnt = 16'd0;
    logic [15:0] blk_cnt = 16'd0;

    logic [2:0]  tick_queue [$];
    t_out_word   pending_reports [$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          in_gap = 0;
    int          out_wait = 0;
    bit          stall_on = 1'b1;

    // press/release run generator
    bit          btn_down [NUM_BUTTONS] = '{1'b0, 1'b0, 1'b0};
    int          run_left [NUM_BUTTONS] = '{0, 0, 0};

    function automatic t_out_word classify_tick(input logic [2:0] raw);
        t_out_word            r;
        logic [2:0]           now_pressed;
        logic [EVT_WIDTH-1:0] evt [NUM_BUTTONS];
        logic [16:0]          nb;
        now_pressed = ~raw;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            evt[b] = EVT_NONE;
            if (now_pressed[b]) begin
                if (hold_cnt[b] != HOLD_MAX) hold_cnt[b] = hold_cnt[b] + 16'd1;
            end else if (was_pressed[b]) begin
                evt[b] = (hold_cnt[b] < lp_ticks) ? EVT_SHORT : EVT_LONG;
                hold_cnt[b] = 16'd0;
            end
        end
        was_pressed = now_pressed;
        r.button1_event = evt[0];
        r.button2_event = evt[1];
        r.button3_event = evt[2];
        if ({1'b0, upd_cnt} + 17'd1 >= {1'b0, upd_period}) begin
            r.update_pulse = 1'b1;
            upd_cnt = 16'd0;
        end else begin
            r.update_pulse = 1'b0;
            upd_cnt = upd_cnt + 16'd1;
        end
        r.blink_on = (blk_cnt < blk_on);
        nb = {1'b0, blk_cnt} + 17'd1;
        if (nb >= {1'b0, blk_period}) nb = 17'd0;
        blk_cnt = nb[15:0];
        return r;
    endfunction

    function automatic int draw_wait();
        return stall_on ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic int draw_run();
        int thr;
        int pick;
        thr = {16'd0, lp_ticks};
        pick = $urandom_range(0, 5);
        if (thr > 60 || thr == 0) thr = $urandom_range(1, 40);
        case (pick)
            0: return $urandom_range(1, 3);
            1: return (thr > 1) ? thr - 1 : 1;
            2: return thr;
            3: return thr + 1;
            default: return $urandom_range(1, 2 * thr + 2);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || pending_reports.size() != 0 || in_if.valid);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] lp, input logic [15:0] up,
                              input logic [15:0] bp, input logic [15:0] bo);
        logic [15:0] vals [4];
        logic [1:0]  idxs [4];
        vals = '{lp, up, bp, bo};
        idxs = '{REG_LONG_PRESS_TICKS, REG_UPDATE_PERIOD, REG_BLINK_PERIOD, REG_BLINK_ON_TICKS};
        wait_idle();
        @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= '{index: idxs[r], value: vals[r]};
            do @(posedge i_clk);
            while (!cfg_if.ready);
            case (idxs[r])
                REG_LONG_PRESS_TICKS: lp_ticks   = vals[r];
                REG_UPDATE_PERIOD:    upd_period = vals[r];
                REG_BLINK_PERIOD:     blk_period = vals[r];
                REG_BLINK_ON_TICKS:   blk_on     = vals[r];
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_directed(input string pat);
        @(negedge i_clk);
        for (int i = 0; i < pat.len(); i++) tick_queue.push_back(3'(pat[i] - 8'd48));
    endtask

    task automatic queue_ticks(input int n);
        logic [2:0] raw;
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                raw = 3'($urandom_range(0, 7));
            end else begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (run_left[b] == 0) begin
                        btn_down[b] = !btn_down[b];
                        run_left[b] = draw_run();
                    end
                    run_left[b]--;
                    raw[b] = !btn_down[b];
                end
            end
            tick_queue.push_back(raw);
        end
    endtask

    // tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            in_gap      <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                pending_reports.push_back(classify_tick(in_if.data.buttons_raw));
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_if.valid <= 1'b0;
                    in_gap      <= in_gap - 1;
                end else if (tick_queue.size() > 0) begin
                    in_if.valid            <= 1'b1;
                    in_if.data.buttons_raw <= tick_queue.pop_front();
                    in_gap                 <= draw_wait();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        t_out_word want;
        int        w;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_wait     <= 0;
        end else if (out_if.ready) begin
            if (out_if.valid) begin
                if (pending_reports.size() == 0) begin
                    fail_count++;
                    $error("result word with none expected");
                end else begin
                    want = pending_reports.pop_front();
                    check_field("button1_event", want.button1_event, out_if.data.button1_event);
                    check_field("button2_event", want.button2_event, out_if.data.button2_event);
                    check_field("button3_event", want.button3_event, out_if.data.button3_event);
                    check_field("update_pulse", {1'b0, want.update_pulse},
                                {1'b0, out_if.data.update_pulse});
                    check_field("blink_on", {1'b0, want.blink_on}, {1'b0, out_if.data.blink_on});
                end
                w = draw_wait();
                if (w > 0) begin
                    out_if.ready <= 1'b0;
                    out_wait     <= w;
                end
            end
        end else begin
            if (out_wait <= 1) out_if.ready <= 1'b1;
            out_wait <= out_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [15:0] bp;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, then short and long release per button
        queue_directed("7707666537");
        set_config(16'd2, 16'd3, 16'd4, 16'd1);
        queue_directed("67667000725717");

        set_config(RST_LONG_PRESS_TICKS, RST_UPDATE_PERIOD, RST_BLINK_PERIOD, RST_BLINK_ON_TICKS);
        queue_ticks(150);
        wait_idle();
        queue_ticks(150);

        set_config(16'd1, 16'd1, 16'd1, 16'd0);
        queue_ticks(200);
        set_config(16'd0, 16'd0, 16'd0, 16'd1);
        queue_ticks(150);

        stall_on = 1'b0;
        set_config(16'd3, 16'd2, 16'd3, 16'hFFFF);
        queue_ticks(200);
        stall_on = 1'b1;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_ticks(200);

        // lower the periods below the running counters
        stall_on = 1'b0;
        set_config(16'd5, 16'd50, 16'd40, 16'd20);
        queue_ticks(30);
        stall_on = 1'b1;
        set_config(16'd5, 16'd5, 16'd4, 16'd2);
        queue_ticks(60);

        repeat (4) begin
            bp = 16'($urandom_range(1, 20));
            set_config(16'($urandom_range(1, 30)), 16'($urandom_range(1, 20)), bp,
                       16'($urandom_range(0, bp + 2)));
            queue_ticks(150);
        end

        set_config(16'd7, 16'd9, 16'd6, 16'd3);
        queue_ticks(150);

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
